// ----- design/tbcm_pkg.sv -----
package tbcm_pkg;

  typedef enum logic [1:0] {
    CMD_CLAIM_RENDER    = 2'd0,
    CMD_RELEASE_RENDER  = 2'd1,
    CMD_CLAIM_DISPLAY   = 2'd2,
    CMD_RELEASE_DISPLAY = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OUTSTANDING = 3'd1,
    ST_NO_FREE     = 3'd2,
    ST_BAD_INDEX   = 3'd3,
    ST_NOT_BUSY    = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e       command;
    logic [3:0] buffer_index;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] granted_buffer;
    logic       tearing_warning;
  } out_item_t;

endpackage

// ----- design/triple_buffer_claim_manager_top.sv -----
// Frame buffer ownership manager for one renderer and one display. Each command item
// (claim render, release render, claim display, release display) gives exactly one result
// item with a status, the granted buffer and a tearing warning. Items pass an input
// register and a result register; the buffer state is read and updated as an item moves
// from the one to the other, which lets one item be accepted every cycle while the output
// side keeps taking results.
module triple_buffer_claim_manager_top import tbcm_pkg::*; #(
  parameter int NUM_BUFFERS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      step;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  tbcm_core #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_failed_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK
      |-> out_item_o.granted_buffer == 3'd0 && !out_item_o.tearing_warning)
    else $error("failed command carries a grant or warning");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.granted_buffer < 3'(NUM_BUFFERS - 1) + 3'd1
      || out_item_o.granted_buffer == 3'(NUM_BUFFERS - 1))
    else $error("granted buffer out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_release_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_item_q.command == CMD_RELEASE_RENDER
      || in_item_q.command == CMD_RELEASE_DISPLAY)
      |=> out_valid_o && out_item_o.granted_buffer == 3'd0)
    else $error("release produced a grant");

endmodule

// ----- design/tbcm_core.sv -----
module tbcm_core import tbcm_pkg::*; #(
  parameter int NUM_BUFFERS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  localparam int IdxW = (NUM_BUFFERS > 2) ? $clog2(NUM_BUFFERS) : 1;

  logic [NUM_BUFFERS-1:0] busy_q, busy_d;
  logic [IdxW-1:0]        last_q, last_d;
  logic                   outstanding_q, outstanding_d;

  logic [NUM_BUFFERS-1:0] free_mask;
  logic                   found;
  logic [IdxW-1:0]        pick;
  logic                   idx_ok;
  logic [IdxW-1:0]        rel_idx;

  // lowest free buffer that is not the last rendered one
  always_comb begin
    free_mask = ~busy_q & ~(NUM_BUFFERS'(1) << last_q);
    found     = 1'b0;
    pick      = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        found = 1'b1;
        pick  = IdxW'(i);
      end
    end
  end

  assign idx_ok  = item_i.buffer_index < 4'(NUM_BUFFERS);
  assign rel_idx = item_i.buffer_index[IdxW-1:0];

  always_comb begin
    busy_d        = busy_q;
    last_d        = last_q;
    outstanding_d = outstanding_q;
    result_o      = '{status: ST_OK, granted_buffer: 3'd0, tearing_warning: 1'b0};
    unique case (item_i.command)
      CMD_CLAIM_RENDER: begin
        if (outstanding_q) begin
          result_o.status = ST_OUTSTANDING;
        end else if (found) begin
          busy_d[pick]            = 1'b1;
          outstanding_d           = 1'b1;
          result_o.granted_buffer = 3'(pick);
        end else begin
          result_o.status = ST_NO_FREE;
        end
      end
      CMD_RELEASE_RENDER: begin
        if (!idx_ok) begin
          result_o.status = ST_BAD_INDEX;
        end else if (!busy_q[rel_idx]) begin
          result_o.status = ST_NOT_BUSY;
        end else begin
          busy_d[rel_idx] = 1'b0;
          last_d          = rel_idx;
          outstanding_d   = 1'b0;
        end
      end
      CMD_CLAIM_DISPLAY: begin
        result_o.tearing_warning = busy_q[last_q];
        busy_d[last_q]           = 1'b1;
        result_o.granted_buffer  = 3'(last_q);
      end
      CMD_RELEASE_DISPLAY: begin
        if (!idx_ok) begin
          result_o.status = ST_BAD_INDEX;
        end else if (!busy_q[rel_idx]) begin
          result_o.status = ST_NOT_BUSY;
        end else begin
          busy_d[rel_idx] = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= '0;
      last_q        <= '0;
      outstanding_q <= 1'b0;
    end else if (step_i) begin
      busy_q        <= busy_d;
      last_q        <= last_d;
      outstanding_q <= outstanding_d;
    end
  end

endmodule
